// ===== sv/cartesian_polar_vector_unit_top_macros.svh =====
// Assertion macros shared by the cartesian / polar vector unit.
`ifndef CARTESIAN_POLAR_VECTOR_UNIT_TOP_MACROS_SVH
`define CARTESIAN_POLAR_VECTOR_UNIT_TOP_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define CPV_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpv: implication check failed");

// A value that must not move in the cycle after the condition.
`define CPV_HOLD(lbl, clk, rst, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error("cpv: value changed while the pipeline was held");

`endif

// ===== sv/cpv_pkg.sv =====
// Package with the types, constants and tables of the cartesian / polar vector unit.
package cpv_pkg;

  // Default number of CORDIC micro-rotations per conversion.
  localparam int CORDIC_STEPS = 28;

  // Internal coordinate width (Q.32 with headroom) and angle width (Q.30).
  localparam int XW = 54;
  localparam int ZW = 36;
  // Magnitude widths fed to the gain multipliers.
  localparam int MW_IN  = 49;
  localparam int MW_RAD = 52;

  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [32:0]   RADIUS_MAX  = 33'sd3037000499;

  typedef enum logic [1:0] {
    CMD_TO_POLAR = 2'd0,
    CMD_TO_CART  = 2'd1,
    CMD_ADD      = 2'd2,
    CMD_SUB      = 2'd3
  } cmd_t;

  // One CORDIC lane: coordinates and residual angle.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  // atan(2^-i) in Q.30, truncated.
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  // Unsigned 64-bit quotient by restoring shift-and-subtract.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // CORDIC gain in Q.31, evaluated at elaboration: K^2 is reduced once per
  // micro-rotation, then an integer square root gives K.
  function automatic logic [30:0] gain_q31(input int steps);
    logic [63:0] k2;
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] dv;
    int          n;
    k2   = 64'd1 << 62;
    res  = '0;
    bitv = 64'd1 << 62;
    dv   = '0;
    n    = (steps > 32) ? 32 : steps;
    for (int i = 0; i < 32; i++) begin
      if (i < n) begin
        dv = (64'd1 << (2 * i)) + 64'd1;
        k2 = k2 - udiv64(k2, dv);
      end
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv > k2) begin
        bitv = bitv >> 2;
      end
    end
    for (int j = 0; j < 32; j++) begin
      if (bitv != 64'd0) begin
        if (k2 >= res + bitv) begin
          k2  = k2 - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
    end
    return res[30:0];
  endfunction

endpackage

// ===== sv/cpv_if.sv =====
// Valid / ready channel interfaces for the request and result transactions.
interface cpv_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [32:0] lhs_a;
  logic signed [31:0] lhs_b;
  logic [31:0]        rhs_a;
  logic signed [30:0] rhs_b;

  modport source (output valid, output cmd, output lhs_a, output lhs_b,
                  output rhs_a, output rhs_b, input ready);
  modport sink (input valid, input cmd, input lhs_a, input lhs_b,
                input rhs_a, input rhs_b, output ready);
endinterface

interface cpv_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] out_a;
  logic signed [31:0] out_b;
  logic               saturated;

  modport source (output valid, output out_a, output out_b, output saturated,
                  input ready);
  modport sink (input valid, input out_a, input out_b, input saturated,
                output ready);
endinterface

// ===== sv/cpv_gain_mul.sv =====
// Two-stage multiplier of a magnitude by the CORDIC gain, rounded at bit 31.
module cpv_gain_mul #(
  parameter int          MW = cpv_pkg::MW_IN,
  parameter logic [30:0] K  = cpv_pkg::gain_q31(cpv_pkg::CORDIC_STEPS)
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [MW-1:0] mag,
  output logic [MW-1:0] prod
);

  logic [MW-1:0] hi_ext;
  logic [61:0]   lo_ext;
  logic [MW-1:0] hi_prod;
  logic [61:0]   lo_prod;
  logic [61:0]   lo_rnd;

  // Split the magnitude at bit 31 so each product stays near 32 x 32 bits.
  assign hi_ext = MW'(mag[MW-1:31]);
  assign lo_ext = 62'(mag[30:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      hi_prod <= hi_ext * MW'(K);
      lo_prod <= lo_ext * 62'(K);
    end
  end

  // Round the low partial product and add the high one.
  assign lo_rnd = lo_prod + (62'd1 << 30);

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= hi_prod + MW'(lo_rnd[61:31]);
    end
  end

endmodule

// ===== sv/cpv_cordic_stage.sv =====
// One registered CORDIC micro-rotation, in rotation or vectoring mode.
module cpv_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          adv,
  input  logic          vectoring,
  input  logic          en,
  input  cpv_pkg::vec_t d,
  output cpv_pkg::vec_t q
);

  localparam logic signed [cpv_pkg::ZW-1:0] ANG = cpv_pkg::ZW'(cpv_pkg::ATAN_Q30[STEP]);

  logic signed [cpv_pkg::XW-1:0] dx;
  logic signed [cpv_pkg::XW-1:0] dy;
  logic                          up;
  cpv_pkg::vec_t                 nxt;

  // Direction: vectoring drives y to zero, rotation drives z to zero.
  // Each coordinate moves by the other one shifted down by the step.
  always_comb begin
    dx = d.y >>> STEP;
    dy = d.x >>> STEP;
    up = vectoring ? (d.y >= 0) : (d.z < 0);
    nxt = d;
    if (en) begin
      if (up) begin
        nxt.x = d.x + dx;
        nxt.y = d.y - dy;
        nxt.z = d.z + ANG;
      end else begin
        nxt.x = d.x - dx;
        nxt.y = d.y + dy;
        nxt.z = d.z - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q <= nxt;
    end
  end

endmodule

// ===== sv/cartesian_polar_vector_unit_top.sv =====
// Cartesian / polar vector unit: a fully pipelined CORDIC converter.
//
// Requests arrive on req, results leave on rsp; both are valid / ready
// channels and a transaction completes when valid and ready are high at a
// rising edge of clk. Commands: to polar, to cartesian, polar add and
// polar subtract. Every request gives exactly one result.
// The pipeline runs through angle folding and gain scaling, STEPS rotation
// stages, one combine stage, one vectoring set-up stage, STEPS vectoring
// stages, gain scaling and rounding into the output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// each stage has its own valid bit so bubbles travel down the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and req.ready drops; nothing is dropped or repeated.
// A synchronous reset empties every stage; there is no other state.
`include "cartesian_polar_vector_unit_top_macros.svh"

module cartesian_polar_vector_unit_top #(
  parameter int STEPS = cpv_pkg::CORDIC_STEPS
) (
  input logic       clk,
  input logic       rst,
  cpv_in_if.sink    req,
  cpv_out_if.source rsp
);

  localparam int          XW  = cpv_pkg::XW;
  localparam int          ZW  = cpv_pkg::ZW;
  localparam int          QW  = XW - 16;
  localparam int          RQW = cpv_pkg::MW_RAD - 16;
  localparam logic [30:0] K   = cpv_pkg::gain_q31(STEPS);

  logic adv;

  // The pipeline moves whenever the output register is free or being read.
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // Bring an angle into [-pi, pi] with one step of 2*pi.
  function automatic logic signed [ZW-1:0] wrap_pi(input logic signed [ZW-1:0] z);
    if (z > cpv_pkg::PI_Q30) begin
      return z - cpv_pkg::TWO_PI_Q30;
    end else if (z < -cpv_pkg::PI_Q30) begin
      return z + cpv_pkg::TWO_PI_Q30;
    end
    return z;
  endfunction

  // Q.32 to Q16.16 with rounding half away from zero; clipped, flag on top.
  function automatic logic [32:0] coord_out(input logic signed [XW-1:0] v);
    logic [XW-1:0] m;
    logic [XW-1:0] s;
    logic [QW-1:0] qv;
    logic [QW-1:0] nq;
    m  = (v < 0) ? XW'(-v) : XW'(v);
    s  = m + XW'(32768);
    qv = s[XW-1:16];
    nq = -qv;
    if (v < 0) begin
      if (qv > QW'(33'h0_8000_0000)) begin
        return {1'b1, 32'h8000_0000};
      end
      return {1'b0, nq[31:0]};
    end
    if (qv > QW'(33'h0_7FFF_FFFF)) begin
      return {1'b1, 32'h7FFF_FFFF};
    end
    return {1'b0, qv[31:0]};
  endfunction

  // ------------------------------------------------------------------
  // Stage 1: fold the input angles and start the gain products.
  // ------------------------------------------------------------------
  logic [32:0]                  abs_a;
  logic [cpv_pkg::MW_IN-1:0]    mag_a;
  logic [cpv_pkg::MW_IN-1:0]    mag_b;
  logic [cpv_pkg::MW_IN-1:0]    p_a;
  logic [cpv_pkg::MW_IN-1:0]    p_b;
  logic signed [ZW-1:0]         za_in;
  logic signed [ZW-1:0]         zb_in;

  assign abs_a = (req.lhs_a < 0) ? 33'(-req.lhs_a) : 33'(req.lhs_a);
  assign mag_a = {abs_a, 16'b0};
  assign mag_b = {1'b0, req.rhs_a, 16'b0};
  assign za_in = ZW'(req.lhs_b) <<< 2;
  assign zb_in = ZW'(req.rhs_b) <<< 2;

  cpv_gain_mul #(.MW(cpv_pkg::MW_IN), .K(K)) u_gain_a (
    .clk (clk), .adv (adv), .mag (mag_a), .prod (p_a)
  );

  cpv_gain_mul #(.MW(cpv_pkg::MW_IN), .K(K)) u_gain_b (
    .clk (clk), .adv (adv), .mag (mag_b), .prod (p_b)
  );

  logic                 r1_vld;
  cpv_pkg::cmd_t        r1_cmd;
  logic signed [ZW-1:0] r1_za;
  logic signed [ZW-1:0] r1_zb;
  logic                 r1_nega;
  logic signed [32:0]   r1_a;
  logic signed [31:0]   r1_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_vld <= 1'b0;
    end else if (adv) begin
      r1_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_cmd  <= cpv_pkg::cmd_t'(req.cmd);
      r1_za   <= wrap_pi(za_in);
      r1_zb   <= wrap_pi(zb_in);
      r1_nega <= (req.lhs_a < 0);
      r1_a    <= req.lhs_a;
      r1_b    <= req.lhs_b;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: move the angles into the right half plane.
  // ------------------------------------------------------------------
  logic signed [ZW-1:0] za_h;
  logic signed [ZW-1:0] zb_h;
  logic                 flip_a;
  logic                 flip_b;

  always_comb begin
    za_h   = r1_za;
    flip_a = 1'b0;
    if (r1_za > cpv_pkg::HALF_PI_Q30) begin
      za_h   = r1_za - cpv_pkg::PI_Q30;
      flip_a = 1'b1;
    end else if (r1_za < -cpv_pkg::HALF_PI_Q30) begin
      za_h   = r1_za + cpv_pkg::PI_Q30;
      flip_a = 1'b1;
    end
    zb_h   = r1_zb;
    flip_b = 1'b0;
    if (r1_zb > cpv_pkg::HALF_PI_Q30) begin
      zb_h   = r1_zb - cpv_pkg::PI_Q30;
      flip_b = 1'b1;
    end else if (r1_zb < -cpv_pkg::HALF_PI_Q30) begin
      zb_h   = r1_zb + cpv_pkg::PI_Q30;
      flip_b = 1'b1;
    end
  end

  logic                 r2_vld;
  cpv_pkg::cmd_t        r2_cmd;
  logic signed [ZW-1:0] r2_za;
  logic signed [ZW-1:0] r2_zb;
  logic                 r2_nega;
  logic                 r2_flipa;
  logic                 r2_flipb;
  logic signed [32:0]   r2_a;
  logic signed [31:0]   r2_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_vld <= 1'b0;
    end else if (adv) begin
      r2_vld <= r1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_cmd   <= r1_cmd;
      r2_za    <= za_h;
      r2_zb    <= zb_h;
      r2_nega  <= r1_nega;
      r2_flipa <= flip_a;
      r2_flipb <= flip_b;
      r2_a     <= r1_a;
      r2_b     <= r1_b;
    end
  end

  // ------------------------------------------------------------------
  // Rotation lanes. Lane A carries the raw x, y untouched for to-polar.
  // ------------------------------------------------------------------
  cpv_pkg::vec_t rot_a   [0:STEPS];
  cpv_pkg::vec_t rot_b   [0:STEPS];
  logic          rot_vld [0:STEPS];
  cpv_pkg::cmd_t rot_cmd [0:STEPS];

  logic signed [XW-1:0] pa_s;
  logic signed [XW-1:0] pb_s;

  assign pa_s = signed'(XW'(p_a));
  assign pb_s = signed'(XW'(p_b));

  always_comb begin
    if (r2_cmd == cpv_pkg::CMD_TO_POLAR) begin
      rot_a[0].x = XW'(r2_a) <<< 16;
      rot_a[0].y = XW'(r2_b) <<< 16;
      rot_a[0].z = '0;
    end else begin
      rot_a[0].x = (r2_nega ^ r2_flipa) ? -pa_s : pa_s;
      rot_a[0].y = '0;
      rot_a[0].z = r2_za;
    end
    rot_b[0].x = r2_flipb ? -pb_s : pb_s;
    rot_b[0].y = '0;
    rot_b[0].z = r2_zb;
  end

  assign rot_vld[0] = r2_vld;
  assign rot_cmd[0] = r2_cmd;

  for (genvar g = 0; g < STEPS; g++) begin : g_rot
    cpv_cordic_stage #(.STEP(g)) u_lane_a (
      .clk       (clk),
      .adv       (adv),
      .vectoring (1'b0),
      .en        (rot_cmd[g] != cpv_pkg::CMD_TO_POLAR),
      .d         (rot_a[g]),
      .q         (rot_a[g+1])
    );

    cpv_cordic_stage #(.STEP(g)) u_lane_b (
      .clk       (clk),
      .adv       (adv),
      .vectoring (1'b0),
      .en        (1'b1),
      .d         (rot_b[g]),
      .q         (rot_b[g+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        rot_vld[g+1] <= 1'b0;
      end else if (adv) begin
        rot_vld[g+1] <= rot_vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rot_cmd[g+1] <= rot_cmd[g];
      end
    end
  end

  // ------------------------------------------------------------------
  // Combine stage: add or subtract the two cartesian operands; other commands pass lane A.
  // ------------------------------------------------------------------
  logic signed [XW-1:0] cx;
  logic signed [XW-1:0] cy;

  always_comb begin
    case (rot_cmd[STEPS])
      cpv_pkg::CMD_ADD: begin
        cx = rot_a[STEPS].x + rot_b[STEPS].x;
        cy = rot_a[STEPS].y + rot_b[STEPS].y;
      end
      cpv_pkg::CMD_SUB: begin
        cx = rot_a[STEPS].x - rot_b[STEPS].x;
        cy = rot_a[STEPS].y - rot_b[STEPS].y;
      end
      default: begin
        cx = rot_a[STEPS].x;
        cy = rot_a[STEPS].y;
      end
    endcase
  end

  logic                 rc_vld;
  cpv_pkg::cmd_t        rc_cmd;
  logic signed [XW-1:0] rc_x;
  logic signed [XW-1:0] rc_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      rc_vld <= 1'b0;
    end else if (adv) begin
      rc_vld <= rot_vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rc_cmd <= rot_cmd[STEPS];
      rc_x   <= cx;
      rc_y   <= cy;
    end
  end

  // ------------------------------------------------------------------
  // Vectoring set-up: fold the left half plane onto the right one.
  // ------------------------------------------------------------------
  cpv_pkg::vec_t vec      [0:STEPS];
  logic          vec_vld  [0:STEPS];
  cpv_pkg::cmd_t vec_cmd  [0:STEPS];
  logic          vec_zero [0:STEPS];
  cpv_pkg::vec_t vp;

  always_comb begin
    vp.x = rc_x;
    vp.y = rc_y;
    vp.z = '0;
    if (rc_cmd != cpv_pkg::CMD_TO_CART && rc_x < 0) begin
      vp.x = -rc_x;
      vp.y = -rc_y;
      vp.z = (rc_y >= 0) ? cpv_pkg::PI_Q30 : -cpv_pkg::PI_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_vld[0] <= 1'b0;
    end else if (adv) begin
      vec_vld[0] <= rc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec[0]      <= vp;
      vec_cmd[0]  <= rc_cmd;
      vec_zero[0] <= (rc_x == 0) && (rc_y == 0);
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_vec
    cpv_cordic_stage #(.STEP(g)) u_lane_v (
      .clk       (clk),
      .adv       (adv),
      .vectoring (1'b1),
      .en        (vec_cmd[g] != cpv_pkg::CMD_TO_CART),
      .d         (vec[g]),
      .q         (vec[g+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        vec_vld[g+1] <= 1'b0;
      end else if (adv) begin
        vec_vld[g+1] <= vec_vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        vec_cmd[g+1]  <= vec_cmd[g];
        vec_zero[g+1] <= vec_zero[g];
      end
    end
  end

  // ------------------------------------------------------------------
  // Radius gain scaling, two stages, with the side data alongside.
  // ------------------------------------------------------------------
  logic [cpv_pkg::MW_RAD-1:0] mag_r;
  logic [cpv_pkg::MW_RAD-1:0] p_r;

  assign mag_r = vec[STEPS].x[cpv_pkg::MW_RAD-1:0];

  cpv_gain_mul #(.MW(cpv_pkg::MW_RAD), .K(K)) u_gain_r (
    .clk (clk), .adv (adv), .mag (mag_r), .prod (p_r)
  );

  logic          f1_vld;
  logic          f2_vld;
  cpv_pkg::cmd_t f1_cmd;
  cpv_pkg::cmd_t f2_cmd;
  logic          f1_zero;
  logic          f2_zero;
  cpv_pkg::vec_t f1_v;
  cpv_pkg::vec_t f2_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
    end else if (adv) begin
      f1_vld <= vec_vld[STEPS];
      f2_vld <= f1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_cmd  <= vec_cmd[STEPS];
      f1_zero <= vec_zero[STEPS];
      f1_v    <= vec[STEPS];
      f2_cmd  <= f1_cmd;
      f2_zero <= f1_zero;
      f2_v    <= f1_v;
    end
  end

  // ------------------------------------------------------------------
  // Output rounding and clipping.
  // ------------------------------------------------------------------
  logic [32:0]                cx_out;
  logic [32:0]                cy_out;
  logic [cpv_pkg::MW_RAD-1:0] rad_s;
  logic [RQW-1:0]             rad_q;
  logic [ZW-1:0]              ang_m;
  logic [ZW-1:0]              ang_s;
  logic [ZW-3:0]              ang_q;
  logic [ZW-3:0]              ang_n;
  logic signed [32:0]         oa;
  logic signed [31:0]         ob;
  logic                       osat;

  always_comb begin
    cx_out = coord_out(f2_v.x);
    cy_out = coord_out(f2_v.y);
    rad_s  = p_r + cpv_pkg::MW_RAD'(32768);
    rad_q  = rad_s[cpv_pkg::MW_RAD-1:16];
    ang_m  = (f2_v.z < 0) ? ZW'(-f2_v.z) : ZW'(f2_v.z);
    ang_s  = ang_m + ZW'(2);
    ang_q  = ang_s[ZW-1:2];
    ang_n  = -ang_q;
    if (f2_cmd == cpv_pkg::CMD_TO_CART) begin
      oa   = signed'(33'(signed'(cx_out[31:0])));
      ob   = signed'(cy_out[31:0]);
      osat = cx_out[32] | cy_out[32];
    end else begin
      if (rad_q > RQW'(cpv_pkg::RADIUS_MAX)) begin
        oa   = cpv_pkg::RADIUS_MAX;
        osat = 1'b1;
      end else begin
        oa   = signed'(rad_q[32:0]);
        osat = 1'b0;
      end
      if (f2_zero) begin
        ob = '0;
      end else if (f2_v.z < 0) begin
        ob = signed'(ang_n[31:0]);
      end else begin
        ob = signed'(ang_q[31:0]);
      end
    end
  end

  cpv_pkg::cmd_t out_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= f2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.out_a     <= oa;
      rsp.out_b     <= ob;
      rsp.saturated <= osat;
      out_cmd       <= f2_cmd;
    end
  end

  // ------------------------------------------------------------------
  // Checks.
  // ------------------------------------------------------------------
  logic [4:0] stage_vld;

  assign stage_vld = {r1_vld, r2_vld, rc_vld, f1_vld, f2_vld};

  `CPV_IMPLY(a_radius_range, clk, rst, rsp.valid && out_cmd != cpv_pkg::CMD_TO_CART, rsp.out_a >= 0 && rsp.out_a <= cpv_pkg::RADIUS_MAX)
  `CPV_IMPLY(a_radius_clip, clk, rst, rsp.valid && rsp.saturated && out_cmd != cpv_pkg::CMD_TO_CART, rsp.out_a == cpv_pkg::RADIUS_MAX)
  `CPV_HOLD(a_stall_holds_stages, clk, rst, !adv, stage_vld)

endmodule

// ===== bench/cartesian_polar_vector_unit_top_tb.sv =====
// Self-checking testbench for the cartesian / polar vector unit.
`timescale 1ns / 100ps

module cartesian_polar_vector_unit_top_tb;

  localparam longint LHS_A_MIN = -64'sd2147483648;
  localparam longint RAD_LIMIT = 64'sd3037000499;
  localparam longint COORD_HI  = 64'sd2147483647;
  localparam longint COORD_LO  = -64'sd2147483648;
  localparam longint ANG_LIMIT = 64'sd843314857;
  localparam longint PI_Z      = 64'sd3373259426;
  localparam longint HALF_PI_Z = 64'sd1686629713;
  localparam longint TWO_PI_Z  = 64'sd6746518852;

  typedef struct {
    cpv_pkg::cmd_t      cmd;
    logic signed [32:0] lhs_a;
    logic signed [31:0] lhs_b;
    logic [31:0]        rhs_a;
    logic signed [30:0] rhs_b;
  } request_t;

  typedef struct {
    logic signed [32:0] a;
    logic signed [31:0] b;
    logic               sat;
  } vector_result_t;

  logic clk;
  logic rst;

  cpv_in_if  req();
  cpv_out_if rsp();

  cartesian_polar_vector_unit_top i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  request_t       pending_requests[$];
  vector_result_t expected_vectors[$];
  int             mismatches = 0;
  int             send_idle_pct = 0;
  int             stall_pct = 0;
  int             hold_left = 0;
  logic           req_taken = 1'b0;
  longint unsigned cordic_gain;

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // CORDIC gain in Q.31: K^2 reduced per micro-rotation, then an integer square root.
  function automatic longint unsigned calc_gain();
    longint unsigned ksq;
    longint unsigned root;
    longint unsigned probe;
    int              n;
    ksq   = 64'd1 << 62;
    root  = 0;
    probe = 64'd1 << 62;
    n     = (cpv_pkg::CORDIC_STEPS > 32) ? 32 : cpv_pkg::CORDIC_STEPS;
    for (int i = 0; i < n; i++) begin
      ksq = ksq - ksq / ((64'd1 << (2 * i)) + 64'd1);
    end
    while (probe > ksq) probe = probe >> 2;
    while (probe != 0) begin
      if (ksq >= root + probe) begin
        ksq  = ksq - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Multiply by the gain, rounding half away from zero at bit 31.
  function automatic longint apply_gain(longint v);
    longint unsigned m;
    longint unsigned p;
    m = (v < 0) ? -v : v;
    p = (m >> 31) * cordic_gain + (((m & 64'h7FFFFFFF) * cordic_gain + (64'd1 << 30)) >> 31);
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint round_down_by(longint v, int s);
    longint unsigned m;
    m = (((v < 0) ? -v : v) + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi, ref logic sat);
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Rotation mode: radius (Q.32) and angle (Q4.28) to x, y in Q.32.
  function automatic void polar_to_xy(input longint r, input longint phi, output longint xo,
                                      output longint yo);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    z = phi * 4;
    y = 0;
    if (z > PI_Z) z -= TWO_PI_Z;
    if (z < -PI_Z) z += TWO_PI_Z;
    x = apply_gain(r);
    if (z > HALF_PI_Z) begin
      z -= PI_Z;
      x = -x;
    end else if (z < -HALF_PI_Z) begin
      z += PI_Z;
      x = -x;
    end
    for (int i = 0; i < cpv_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(cpv_pkg::ATAN_Q30[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(cpv_pkg::ATAN_Q30[i]);
      end
    end
    xo = x;
    yo = y;
  endfunction

  // Vectoring mode: x, y in Q.32 to radius (Q.32) and a full-quadrant angle (Q.30).
  function automatic void xy_to_polar(input longint xi, input longint yi, output longint ro,
                                      output longint ao);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) begin
      ro = 0;
      ao = 0;
    end else begin
      if (x < 0) begin
        z = (y >= 0) ? PI_Z : -PI_Z;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < cpv_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += longint'(cpv_pkg::ATAN_Q30[i]);
        end else begin
          x -= dx;
          y += dy;
          z -= longint'(cpv_pkg::ATAN_Q30[i]);
        end
      end
      ro = apply_gain(x);
      ao = z;
    end
  endfunction

  function automatic vector_result_t predict_vector(request_t t);
    vector_result_t res;
    longint x, y, x2, y2, rad, ang, oa, ob;
    logic   sat;
    sat = 1'b0;
    if (t.cmd == cpv_pkg::CMD_TO_CART) begin
      polar_to_xy(longint'(t.lhs_a) * 65536, longint'(t.lhs_b), x, y);
      oa = clip(round_down_by(x, 16), COORD_LO, COORD_HI, sat);
      ob = clip(round_down_by(y, 16), COORD_LO, COORD_HI, sat);
    end else begin
      if (t.cmd == cpv_pkg::CMD_TO_POLAR) begin
        x = longint'(t.lhs_a) * 65536;
        y = longint'(t.lhs_b) * 65536;
      end else begin
        polar_to_xy(longint'(t.lhs_a) * 65536, longint'(t.lhs_b), x, y);
        polar_to_xy(longint'(t.rhs_a) * 65536, longint'(t.rhs_b), x2, y2);
        if (t.cmd == cpv_pkg::CMD_ADD) begin
          x += x2;
          y += y2;
        end else begin
          x -= x2;
          y -= y2;
        end
      end
      xy_to_polar(x, y, rad, ang);
      oa = clip(round_down_by(rad, 16), 0, RAD_LIMIT, sat);
      ob = round_down_by(ang, 2);
    end
    res.a   = oa[32:0];
    res.b   = ob[31:0];
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("Mismatch on %s: got %0d, expected %0d", field, got, want);
    mismatches++;
  endtask

  function automatic longint rand_between(longint lo, longint hi);
    longint unsigned span;
    span = longint'(hi - lo) + 1;
    return lo + longint'({$urandom(), $urandom()} % span);
  endfunction

  task automatic queue_request(cpv_pkg::cmd_t c, longint la, longint lb, longint ra,
                               longint rb);
    request_t t;
    t.cmd   = c;
    t.lhs_a = la[32:0];
    t.lhs_b = lb[31:0];
    t.rhs_a = ra[31:0];
    t.rhs_b = rb[30:0];
    pending_requests.push_back(t);
  endtask

  // Random request: mostly full-range vectors, sometimes small ones so that sums cancel.
  task automatic queue_random_request();
    cpv_pkg::cmd_t c;
    longint        la, lb, ra, rb;
    c  = cpv_pkg::cmd_t'($urandom_range(3));
    la = ($urandom_range(3) == 0) ? rand_between(-70000, 70000)
                                  : rand_between(LHS_A_MIN, RAD_LIMIT);
    lb = ($urandom_range(1) == 0) ? rand_between(-ANG_LIMIT, ANG_LIMIT)
                                  : longint'($signed($urandom()));
    ra = ($urandom_range(3) == 0) ? rand_between(0, 70000) : rand_between(0, RAD_LIMIT);
    rb = rand_between(-ANG_LIMIT, ANG_LIMIT);
    if (c == cpv_pkg::CMD_TO_POLAR && $urandom_range(3) == 0) lb = rand_between(-70000, 70000);
    // Subtracting an operand from itself gives an exact zero vector.
    if (c == cpv_pkg::CMD_SUB && $urandom_range(15) == 0) begin
      ra = la & 64'h7FFFFFFF;
      la = ra;
      rb = lb % ANG_LIMIT;
      lb = rb;
    end
    queue_request(c, la, lb, ra, rb);
  endtask

  // Sample accepted requests and predict their results.
  always @(posedge clk) begin
    request_t t;
    req_taken = req.valid && req.ready;
    if (req_taken) begin
      t.cmd   = cpv_pkg::cmd_t'(req.cmd);
      t.lhs_a = req.lhs_a;
      t.lhs_b = req.lhs_b;
      t.rhs_a = req.rhs_a;
      t.rhs_b = req.rhs_b;
      expected_vectors.push_back(predict_vector(t));
    end
  end

  // Request driver, fed from the pending queue.
  always @(negedge clk) begin
    request_t t;
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_taken) begin
      if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        t = pending_requests.pop_front();
        req.cmd   <= t.cmd;
        req.lhs_a <= t.lhs_a;
        req.lhs_b <= t.lhs_b;
        req.rhs_a <= t.rhs_a;
        req.rhs_b <= t.rhs_b;
        req.valid <= 1'b1;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Long hold-off counter for the result side.
  always @(negedge clk) begin
    if (hold_left > 0) hold_left = hold_left - 1;
  end

  // Result receiver with random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    vector_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_vectors.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = expected_vectors.pop_front();
        if (rsp.out_a !== want.a) report_mismatch("out_a", rsp.out_a, want.a);
        if (rsp.out_b !== want.b) report_mismatch("out_b", rsp.out_b, want.b);
        if (rsp.saturated !== want.sat) report_mismatch("saturated", rsp.saturated, want.sat);
      end
    end
  end

  // Stimulus: directed corners, then random phases with different idling.
  initial begin
    req.valid = 1'b0;
    req.cmd   = cpv_pkg::CMD_TO_POLAR;
    req.lhs_a = '0;
    req.lhs_b = '0;
    req.rhs_a = '0;
    req.rhs_b = '0;
    rsp.ready = 1'b0;
    cordic_gain = calc_gain();
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Zero vector, quadrants, overflow and the field extremes.
    queue_request(cpv_pkg::CMD_TO_POLAR, 0, 0, 0, 0);
    queue_request(cpv_pkg::CMD_TO_POLAR, -65536, 0, 0, 0);
    queue_request(cpv_pkg::CMD_TO_POLAR, -65536, -1, 0, 0);
    queue_request(cpv_pkg::CMD_TO_POLAR, 0, -65536, 0, 0);
    queue_request(cpv_pkg::CMD_TO_POLAR, RAD_LIMIT, COORD_HI, 0, 0);
    queue_request(cpv_pkg::CMD_TO_POLAR, LHS_A_MIN, COORD_LO, 0, 0);
    queue_request(cpv_pkg::CMD_TO_POLAR, RAD_LIMIT, 0, 0, 0);
    queue_request(cpv_pkg::CMD_TO_CART, 65536, 0, 0, 0);
    queue_request(cpv_pkg::CMD_TO_CART, RAD_LIMIT, 0, 0, 0);
    queue_request(cpv_pkg::CMD_TO_CART, RAD_LIMIT, COORD_HI, 0, 0);
    queue_request(cpv_pkg::CMD_TO_CART, RAD_LIMIT, COORD_LO, 0, 0);
    queue_request(cpv_pkg::CMD_TO_CART, LHS_A_MIN, 421657428, 0, 0);
    queue_request(cpv_pkg::CMD_TO_CART, -65536, 0, 0, 0);
    queue_request(cpv_pkg::CMD_TO_CART, 0, COORD_HI, 0, 0);
    queue_request(cpv_pkg::CMD_ADD, 65536, 0, 65536, ANG_LIMIT);
    queue_request(cpv_pkg::CMD_ADD, RAD_LIMIT, 0, 64'hFFFFFFFF, 0);
    queue_request(cpv_pkg::CMD_ADD, LHS_A_MIN, COORD_LO, RAD_LIMIT, -ANG_LIMIT);
    queue_request(cpv_pkg::CMD_SUB, 131072, 300000000, 131072, 300000000);
    queue_request(cpv_pkg::CMD_SUB, RAD_LIMIT, 0, RAD_LIMIT, ANG_LIMIT);
    queue_request(cpv_pkg::CMD_SUB, 0, 0, 0, 0);
    queue_request(cpv_pkg::CMD_SUB, 65536, COORD_HI, 0, -ANG_LIMIT);
    wait (pending_requests.size() == 0 && expected_vectors.size() == 0);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? 80 : 0;
      stall_pct     = (phase == 2) ? 80 : (phase == 3) ? 17 : 0;
      if (phase == 3) send_idle_pct = 17;
      for (int n = 0; n < 410; n++) queue_random_request();
      // Hold the receiver off so the pipeline fills and backs up.
      if (phase == 0) hold_left = 300;
      wait (pending_requests.size() == 0 && expected_vectors.size() == 0);
    end

    wait (!req.valid);
    wait (expected_vectors.size() == 0);
    repeat (2 * cpv_pkg::CORDIC_STEPS + 40) @(posedge clk);
    if (mismatches == 0 && expected_vectors.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== cartesian_polar_vector_unit_top.f =====
+incdir+sv
sv/cpv_pkg.sv
sv/cpv_if.sv
sv/cpv_gain_mul.sv
sv/cpv_cordic_stage.sv
sv/cartesian_polar_vector_unit_top.sv
bench/cartesian_polar_vector_unit_top_tb.sv
